// ===== hw/rtl/cpd_pkg.sv =====
`timescale 1ns / 1ps

package cpd_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int COORD_W     = 16;
    localparam int SQR_W       = 2 * COORD_W;
    localparam int SQ_W        = SQR_W + 1;
    localparam int BEST_W      = SQ_W + 1;
    localparam int ROOT_W      = (SQ_W + 1) / 2;
    localparam int SQRT_STAGES = ROOT_W;

    localparam logic [BEST_W-1:0] BEST_NONE  = '1;
    localparam logic [BEST_W-1:0] SQRT_BIT0  = BEST_W'(1) << (2 * (SQRT_STAGES - 1));
    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(MAX_POINTS);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // point item travelling along the row of cells
    typedef struct packed {
        point_t             pt;
        logic [CNT_W-1:0]   left;    // stored cells still to compare against
        logic               placed;  // already dropped into a cell
        logic               last;
        logic               ovf;
        logic               nopair;
        logic [BEST_W-1:0]  best;
    } tok_t;

    // one step of the square-root pipe
    typedef struct packed {
        logic [BEST_W-1:0]  rem;
        logic [BEST_W-1:0]  root;
        logic [BEST_W-1:0]  bitv;
        logic [SQ_W-1:0]    sq;
        logic               nopair;
        logic               ovf;
    } sqrt_t;

endpackage

// ===== hw/rtl/cpd_cell.sv =====
`timescale 1ns / 1ps

module cpd_cell
    import cpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  tok_t in_tok,
    output logic out_valid,
    output tok_t out_tok
);

    point_t                 pt_reg;
    logic                   store;
    logic                   cmp_next;
    tok_t                   tok_a_next;
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [SQR_W+1:0] prod_x;
    logic signed [SQR_W+1:0] prod_y;

    logic                   a_valid_reg;
    logic                   a_cmp_reg;
    tok_t                   a_tok_reg;
    logic [SQR_W-1:0]       a_sqx_reg;
    logic [SQR_W-1:0]       a_sqy_reg;

    logic [SQ_W-1:0]        sum_sq;
    tok_t                   tok_b_next;
    logic                   b_valid_reg;
    tok_t                   b_tok_reg;

    assign cmp_next = in_valid && (in_tok.left != '0);
    assign store    = in_valid && (in_tok.left == '0) && !in_tok.placed;

    // stage A: difference and squares against the held point
    assign dx     = {in_tok.pt.x[COORD_W-1], in_tok.pt.x} - {pt_reg.x[COORD_W-1], pt_reg.x};
    assign dy     = {in_tok.pt.y[COORD_W-1], in_tok.pt.y} - {pt_reg.y[COORD_W-1], pt_reg.y};
    assign prod_x = dx * dx;
    assign prod_y = dy * dy;

    always_comb
    begin
        tok_a_next = in_tok;
        if (in_tok.left != '0)
        begin
            tok_a_next.left = in_tok.left - CNT_W'(1);
        end
        else
        begin
            tok_a_next.placed = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            pt_reg <= in_tok.pt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_cmp_reg   <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            a_cmp_reg   <= cmp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_tok_reg <= tok_a_next;
        a_sqx_reg <= prod_x[SQR_W-1:0];
        a_sqy_reg <= prod_y[SQR_W-1:0];
    end

    // stage B: sum and keep the smaller distance
    assign sum_sq = {1'b0, a_sqx_reg} + {1'b0, a_sqy_reg};

    always_comb
    begin
        tok_b_next = a_tok_reg;
        if (a_cmp_reg && ({1'b0, sum_sq} < a_tok_reg.best))
        begin
            tok_b_next.best = {1'b0, sum_sq};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_tok_reg <= tok_b_next;
    end

    assign out_valid = b_valid_reg;
    assign out_tok   = b_tok_reg;

endmodule

// ===== hw/rtl/cpd_sqrt_stage.sv =====
`timescale 1ns / 1ps

module cpd_sqrt_stage
    import cpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  sqrt_t in_s,
    output logic  out_valid,
    output sqrt_t out_s
);

    logic [BEST_W-1:0] trial;
    sqrt_t             s_next;
    logic              valid_reg;
    sqrt_t             s_reg;

    assign trial = in_s.root + in_s.bitv;

    // one result bit: subtract the trial value where it fits
    always_comb
    begin
        s_next      = in_s;
        s_next.bitv = in_s.bitv >> 2;
        if (in_s.rem >= trial)
        begin
            s_next.rem  = in_s.rem - trial;
            s_next.root = (in_s.root >> 1) + in_s.bitv;
        end
        else
        begin
            s_next.root = in_s.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

    assign out_valid = valid_reg;
    assign out_s     = s_reg;

endmodule

// ===== hw/rtl/closest_pair_distance.sv =====
`timescale 1ns / 1ps
// After its last point is taken, a result passes one entry register, two stages in each point cell,
// one reduce register and 17 root steps before it leaves.
// Throughput: one point per cycle, set after set; busy stays low, the row of cells is fully pipelined.
// Each result sits on the ports for exactly one cycle, marked by done; the receiver cannot stall.
// Reset (rst_n, asynchronous, active low) clears the point count, the overflow mark,
// the running minimum and every valid bit; the stored points stay undefined until written.

module closest_pair_distance
    import cpd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic                      last_point,
    output logic                      done,
    output logic [ROOT_W-1:0]         min_distance,
    output logic [SQ_W-1:0]           min_distance_sq,
    output logic                      no_pair,
    output logic                      overflowed
);

    logic              accept;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              full;

    logic              ent_valid_reg;
    tok_t              ent_tok_reg;
    tok_t              ent_tok_next;

    logic              row_valid [MAX_POINTS+1];
    tok_t              row_tok   [MAX_POINTS+1];

    logic              tail_valid;
    tok_t              tail_tok;
    logic [BEST_W-1:0] best_reg;
    logic [BEST_W-1:0] best_next;
    logic [BEST_W-1:0] merged;

    logic              rt_valid_reg;
    sqrt_t             rt_reg;
    sqrt_t             rt_next;
    logic              sq_valid [SQRT_STAGES+1];
    sqrt_t             sq_s     [SQRT_STAGES+1];

    // The row never holds items back, so a point is taken whenever start is high.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_FULL);

    // Entry: tag each point with how many stored points lie ahead of it in the row.
    // A point that finds the store full still compares against all cells but is never placed.
    always_comb
    begin
        ent_tok_next.pt.x   = coord_x;
        ent_tok_next.pt.y   = coord_y;
        ent_tok_next.left   = count_reg;
        ent_tok_next.placed = 1'b0;
        ent_tok_next.last   = last_point;
        ent_tok_next.ovf    = ovf_reg || full;
        ent_tok_next.nopair = (count_reg == '0);
        ent_tok_next.best   = BEST_NONE;

        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (last_point)
            begin
                // end of set: the next point starts a fresh set
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            ent_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_tok_reg <= ent_tok_next;
    end

    // Row of point cells: each cell holds one stored point, compares a passing item against
    // it while the item still has cells to compare, and hands it on with its running minimum.
    assign row_valid[0] = ent_valid_reg;
    assign row_tok[0]   = ent_tok_reg;

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        cpd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (row_valid[i]),
            .in_tok    (row_tok[i]),
            .out_valid (row_valid[i+1]),
            .out_tok   (row_tok[i+1])
        );
    end

    assign tail_valid = row_valid[MAX_POINTS];
    assign tail_tok   = row_tok[MAX_POINTS];

    // Reduce: fold each item's minimum into the set minimum; the last item of a
    // set hands the total to the root pipe and clears the minimum.
    assign merged = (tail_tok.best < best_reg) ? tail_tok.best : best_reg;

    always_comb
    begin
        best_next      = best_reg;
        rt_next.rem    = BEST_W'(0);
        rt_next.root   = BEST_W'(0);
        rt_next.bitv   = SQRT_BIT0;
        rt_next.sq     = SQ_W'(0);
        rt_next.nopair = tail_tok.nopair;
        rt_next.ovf    = tail_tok.ovf;
        if (tail_valid)
        begin
            best_next = tail_tok.last ? BEST_NONE : merged;
        end
        if (!tail_tok.nopair)
        begin
            rt_next.sq  = merged[SQ_W-1:0];
            rt_next.rem = {1'b0, merged[SQ_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg     <= BEST_NONE;
            rt_valid_reg <= 1'b0;
        end
        else
        begin
            best_reg     <= best_next;
            rt_valid_reg <= tail_valid && tail_tok.last;
        end
    end

    always_ff @(posedge clk)
    begin
        rt_reg <= rt_next;
    end

    // Root pipe: one result bit per stage, highest bit first.
    assign sq_valid[0] = rt_valid_reg;
    assign sq_s[0]     = rt_reg;

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        cpd_sqrt_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[k]),
            .in_s      (sq_s[k]),
            .out_valid (sq_valid[k+1]),
            .out_s     (sq_s[k+1])
        );
    end

    // Results come straight from the last root stage register.
    assign done            = sq_valid[SQRT_STAGES];
    assign min_distance    = sq_s[SQRT_STAGES].root[ROOT_W-1:0];
    assign min_distance_sq = sq_s[SQRT_STAGES].sq;
    assign no_pair         = sq_s[SQRT_STAGES].nopair;
    assign overflowed      = sq_s[SQRT_STAGES].ovf;

endmodule
